// ===== rtl/lru_key_value_cache_core_assert.svh =====
// assertion macros for the lru key-value cache
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// condition must hold in the same cycle as its trigger
`define LKVC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after its trigger
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps

package lkvc_pkg;

  // number of cells in the recency chain
  localparam int ENTRIES = 16;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // contents of one cell
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

// ===== rtl/lkvc_cell.sv =====
`timescale 1ns / 1ps

module lkvc_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     shift,
  input  lkvc_pkg::entry_t         chain_in,
  input  logic [lkvc_pkg::KEY_W-1:0] probe_key,
  output lkvc_pkg::entry_t         cur,
  output logic                     match
);

  logic                       valid;
  logic [lkvc_pkg::KEY_W-1:0] key;
  logic [lkvc_pkg::VAL_W-1:0] value;

  // take the neighbour's contents when the chain moves past this cell
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= chain_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key   <= chain_in.key;
      value <= chain_in.value;
    end
  end

  // key compare against the item in flight
  assign match = valid && (key == probe_key);
  assign cur   = '{valid: valid, key: key, value: value};

endmodule

// ===== rtl/lru_key_value_cache_core.sv =====
`timescale 1ns / 1ps
// the compare runs on the input register, the result is registered together with the
//   cell update
// throughput: one item per cycle while results are taken; the cell row compares and
//   shifts once per item, the next item sees the updated row
// reset: all cells invalid, entry count 0, capacity 16; no clearing pass
// stored keys and values keep no reset, they are read only from valid cells

module lru_key_value_cache_core (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key [31:0], value [63:32]
  input  logic        s_axis_tuser,  // operation
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // read_value [31:0], evicted_key [63:32]
  output logic [1:0]  m_axis_tuser,  // hit [0], evicted [1]
  // capacity register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int N = lkvc_pkg::ENTRIES;

  // capacity register
  logic [lkvc_pkg::CAP_W-1:0] capacity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // input register
  logic                       pend_valid;
  logic                       pend_op;
  logic [lkvc_pkg::KEY_W-1:0] pend_key;
  logic [lkvc_pkg::VAL_W-1:0] pend_value;
  logic                       fire;
  logic                       out_valid;

  assign fire          = pend_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !pend_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      pend_valid <= 1'b1;
    end else if (fire) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pend_op    <= s_axis_tuser;
      pend_key   <= s_axis_tdata[31:0];
      pend_value <= s_axis_tdata[63:32];
    end
  end

  // cell row, cell 0 most recent
  lkvc_pkg::entry_t cell_q   [N];
  lkvc_pkg::entry_t chain_in [N];
  lkvc_pkg::entry_t new_entry;
  logic [N-1:0]     match;
  logic [N-1:0]     shift;
  logic [N-1:0]     valid_vec;
  logic [N-1:0]     tail_sel;

  logic [lkvc_pkg::CNT_W-1:0] count;
  logic [lkvc_pkg::CNT_W-1:0] count_next;
  logic [lkvc_pkg::CNT_W:0]   limit_excl;
  logic [lkvc_pkg::CMP_W-1:0] eff_cap;
  logic                       is_put;
  logic                       hit;
  logic                       evict;
  logic [lkvc_pkg::VAL_W-1:0] found_value;
  logic [lkvc_pkg::KEY_W-1:0] tail_key;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = new_entry;
    end else begin : g_link
      assign chain_in[i] = cell_q[i-1];
    end

    lkvc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift[i]),
      .chain_in  (chain_in[i]),
      .probe_key (pend_key),
      .cur       (cell_q[i]),
      .match     (match[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
    assign tail_sel[i]  = (lkvc_pkg::CNT_W'(i) == (count - lkvc_pkg::CNT_W'(1)));

    // on a hit the cells up to the match move, on an insert those below the limit
    assign shift[i] = fire && (hit ? (|(match >> i))
                                   : (is_put && ((lkvc_pkg::CNT_W+1)'(i) < limit_excl)));
  end

  // value of the matching cell and key of the least recent cell
  always_comb begin
    found_value = '0;
    tail_key    = '0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) begin
        found_value = found_value | cell_q[i].value;
      end
      if (tail_sel[i]) begin
        tail_key = tail_key | cell_q[i].key;
      end
    end
  end

  // effective capacity, zero counts as one, clamped to the row length
  always_comb begin
    priority if (capacity == '0) begin
      eff_cap = lkvc_pkg::CMP_W'(1);
    end else if (lkvc_pkg::CMP_W'(capacity) > lkvc_pkg::CMP_W'(N)) begin
      eff_cap = lkvc_pkg::CMP_W'(N);
    end else begin
      eff_cap = lkvc_pkg::CMP_W'(capacity);
    end
  end

  assign is_put = (pend_op == lkvc_pkg::OP_PUT);
  assign hit    = |match;
  assign evict  = is_put && !hit && (count != '0) && (lkvc_pkg::CMP_W'(count) >= eff_cap);

  assign limit_excl = evict ? {1'b0, count} : ({1'b0, count} + (lkvc_pkg::CNT_W+1)'(1));

  // entry that goes to the head of the row
  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.key   = pend_key;
    new_entry.value = (hit && !is_put) ? found_value : pend_value;
  end

  // entry count
  assign count_next = (is_put && !hit && !evict) ? (count + lkvc_pkg::CNT_W'(1)) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // output register
  logic                       out_hit;
  logic                       out_evicted;
  logic [lkvc_pkg::VAL_W-1:0] out_read_value;
  logic [lkvc_pkg::KEY_W-1:0] out_evicted_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_hit         <= hit;
      out_evicted     <= evict;
      out_read_value  <= (hit && !is_put) ? found_value : '0;
      out_evicted_key <= evict ? tail_key : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_evicted_key, out_read_value};
  assign m_axis_tuser  = {out_evicted, out_hit};

  // checks
  `include "lru_key_value_cache_core_assert.svh"

  `LKVC_ASSERT_SAME(a_one_match, pend_valid, $onehot0(match), "key held in more than one cell")
  `LKVC_ASSERT_SAME(a_count_valid, 1'b1, $countones(valid_vec) == count, "count off cells")
  `LKVC_ASSERT_SAME(a_hit_no_evict, out_valid, !(out_hit && out_evicted), "eviction on a hit")
  `LKVC_ASSERT_NEXT(a_fire_out, fire, out_valid, "result lost after processing")

endmodule
